// ===== sv/crodc_pkg.sv =====
// shared constants and types for the call record overlap classifier
// no dependencies
package crodc_pkg;

  localparam int SPAN_DEPTH = 64;
  localparam int CNT_W      = $clog2(SPAN_DEPTH + 1);

  localparam logic [3:0] KIND_NONE  = 4'd0;
  localparam logic [3:0] KIND_OTHER = 4'd2;
  localparam logic [3:0] KIND_SDCE  = 4'd3;
  localparam logic [3:0] KIND_SDC   = 4'd4;
  localparam logic [3:0] KIND_SD    = 4'd5;
  localparam logic [3:0] KIND_CE    = 4'd6;
  localparam logic [3:0] KIND_C     = 4'd7;
  localparam logic [3:0] KIND_E     = 4'd8;
  localparam logic [3:0] KIND_DC    = 4'd9;

  typedef struct packed {
    logic [39:0] ident;
    logic [63:0] callee;
    logic [31:0] start;
    logic [23:0] length;
    logic [15:0] exch;
  } rec_t;

  typedef struct packed {
    logic [39:0] matched_id;
    logic [3:0]  dup_kind;
    logic        span_full;
    logic        last_result;
  } res_t;

  function automatic logic [3:0] classify(logic s, logic d, logic c, logic e);
    logic [3:0] k;
    case ({s, d, c, e})
      4'b1111: k = KIND_SDCE;
      4'b1110: k = KIND_SDC;
      4'b1100: k = KIND_SD;
      4'b0011: k = KIND_CE;
      4'b0010: k = KIND_C;
      4'b0001: k = KIND_E;
      4'b0110: k = KIND_DC;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/crodc_if.sv =====
// valid/ready channel interfaces for the classifier
// no dependencies
interface crodc_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [39:0] record_id;
  logic [63:0] caller_key;
  logic [63:0] callee_key;
  logic [31:0] start_seconds;
  logic [23:0] duration_seconds;
  logic [15:0] exchange_id;
  logic        restart_span;
  modport source (output valid, record_id, caller_key, callee_key, start_seconds,
                  duration_seconds, exchange_id, restart_span, input ready);
  modport sink (input valid, record_id, caller_key, callee_key, start_seconds,
                duration_seconds, exchange_id, restart_span, output ready);
endinterface

interface crodc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [39:0] matched_id;
  logic [3:0]  dup_kind;
  logic        span_full;
  logic        last_result;
  modport source (output valid, matched_id, dup_kind, span_full, last_result,
                  input ready);
  modport sink (input valid, matched_id, dup_kind, span_full, last_result,
                output ready);
endinterface

// ===== sv/crodc_cell.sv =====
// one span slot: holds a stored record and compares it with the probe
// uses crodc_pkg
module crodc_cell (
  input  logic                 clk,
  input  logic                 load,
  input  crodc_pkg::rec_t      load_rec,
  input  logic                 shift,
  input  crodc_pkg::rec_t      shift_in,
  input  crodc_pkg::rec_t      probe,
  output crodc_pkg::rec_t      rec,
  output logic                 overlap,
  output logic [3:0]           kind
);
  logic [32:0] finish;

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= load_rec;
    end else if (shift) begin
      rec <= shift_in;
    end
  end

  assign finish  = {1'b0, rec.start} + {9'd0, rec.length};
  assign overlap = {1'b0, probe.start} < finish;
  assign kind    = crodc_pkg::classify(probe.start == rec.start,
                                       probe.length == rec.length,
                                       probe.callee == rec.callee,
                                       probe.exch == rec.exch);
endmodule

// ===== sv/call_record_overlap_dup_classifier.sv =====
// top level of the call record overlap and duplicate classifier
// uses crodc_pkg, crodc_if, crodc_cell
//
// channel  dir  payload
// in_ch    in   record_id caller_key callee_key start/duration exchange restart
// out_ch   out  matched_id dup_kind span_full last_result
//
// a new-span or full record gives a single result, loaded at the edge that
// accepts it, so the input is free again once that result is taken.
// a joining record with n older entries goes through the accept, one scan step
// per older entry as the row rotates, and a closing step that rotates the row
// back into storage order and releases the last hit or a plain closing result.
// each scan step and the closing step wait while a result sits untaken.
// one record at a time: in_ch.ready is low while a scan or a result is open.
// rst is synchronous, active high, and clears the span; stored entries need
// no clearing.
module call_record_overlap_dup_classifier (
  input logic clk,
  input logic rst,
  crodc_in_if.sink    in_ch,
  crodc_out_if.source out_ch
);
  localparam int DEPTH = crodc_pkg::SPAN_DEPTH;
  localparam int CW    = crodc_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] span_count;
  logic [CW-1:0] scan_left;
  logic [32:0]   span_end;
  logic [63:0]   prev_caller;
  logic          prev_caller_valid;
  logic          any_hit;
  crodc_pkg::rec_t probe;

  // result register, and the newest hit held back until the next one shows
  // whether it is the last
  logic            out_valid;
  crodc_pkg::res_t out_res;
  crodc_pkg::res_t hit_res;
  logic            out_load;
  crodc_pkg::res_t out_res_next;

  crodc_pkg::rec_t cell_rec  [DEPTH];
  logic            cell_ov   [DEPTH];
  logic [3:0]      cell_kind [DEPTH];
  logic            load_new;
  logic            shift;
  crodc_pkg::rec_t in_rec;

  logic        accept, fresh, full, new_span;
  logic [32:0] in_finish;
  logic        out_free;

  assign in_rec = '{ident: in_ch.record_id, callee: in_ch.callee_key,
                    start: in_ch.start_seconds, length: in_ch.duration_seconds,
                    exch: in_ch.exchange_id};
  assign in_finish = {1'b0, in_ch.start_seconds} + {9'd0, in_ch.duration_seconds};

  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign load_new = accept && !full;

  assign fresh    = !prev_caller_valid || in_ch.caller_key != prev_caller ||
                    in_ch.restart_span;
  assign full     = !fresh && span_count == CW'(DEPTH);
  assign new_span = fresh || span_count == '0 ||
                    {1'b0, in_ch.start_seconds} >= span_end;

  // row of cells: cell 0 is the head read during the scan; the row rotates
  // over the occupied slots once per scan step, and the closing step makes
  // the rotation a full turn so the row is back in storage order
  assign shift = out_free && (state == ST_SCAN || state == ST_LAST);

  // new records are loaded into the slot at index span_count (or 0 on new span)
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic ld;
    crodc_pkg::rec_t nb;
    assign ld = load_new &&
                (new_span ? (g == 0) : (span_count == CW'(g)));
    // rotation over the occupied slots: slot g takes g+1, last occupied takes 0
    if (g == DEPTH - 1) begin : g_end
      assign nb = cell_rec[0];
    end else begin : g_mid
      assign nb = (CW'(g + 1) == span_count) ? cell_rec[0] : cell_rec[g + 1];
    end
    crodc_cell u_cell (
      .clk(clk), .load(ld), .load_rec(in_rec), .shift(shift),
      .shift_in(nb), .probe(probe), .rec(cell_rec[g]),
      .overlap(cell_ov[g]), .kind(cell_kind[g])
    );
  end

  // what goes into the result register this cycle
  always_comb begin
    out_load = 1'b0;
    out_res_next = '{matched_id: '0, dup_kind: crodc_pkg::KIND_NONE,
                     span_full: 1'b0, last_result: 1'b1};
    unique case (state)
      ST_IDLE: begin
        if (accept && (full || new_span)) begin
          out_load = 1'b1;
          out_res_next.span_full = full;
        end
      end
      ST_SCAN: begin
        // a new hit pushes out the held one, which is then not the last
        if (out_free && cell_ov[0] && any_hit) begin
          out_load = 1'b1;
          out_res_next = hit_res;
        end
      end
      ST_LAST: begin
        // held hit goes out marked last; with no hit, a plain closing result
        if (out_free) begin
          out_load = 1'b1;
          if (any_hit) begin
            out_res_next = hit_res;
            out_res_next.last_result = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_res <= out_res_next;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      span_count <= '0;
      span_end <= '0;
      prev_caller <= '0;
      prev_caller_valid <= 1'b0;
      scan_left <= '0;
      any_hit <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_caller <= in_ch.caller_key;
            prev_caller_valid <= 1'b1;
            probe <= in_rec;
            if (full) begin
              // span unchanged
            end else if (new_span) begin
              span_count <= CW'(1);
              span_end <= in_finish;
            end else begin
              span_count <= span_count + CW'(1);
              if (in_finish > span_end) span_end <= in_finish;
              scan_left <= span_count;
              any_hit <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // cell 0 holds the next older entry; one step per cycle unless a result sits untaken
          if (out_free) begin
            scan_left <= scan_left - CW'(1);
            if (cell_ov[0]) begin
              any_hit <= 1'b1;
              hit_res <= '{matched_id: cell_rec[0].ident, dup_kind: cell_kind[0],
                           span_full: 1'b0, last_result: 1'b0};
            end
            if (scan_left == CW'(1)) state <= ST_LAST;
          end
        end
        ST_LAST: begin
          // head is the new record; one more step restores the row
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.matched_id  = out_res.matched_id;
  assign out_ch.dup_kind    = out_res.dup_kind;
  assign out_ch.span_full   = out_res.span_full;
  assign out_ch.last_result = out_res.last_result;

  // the span never grows past the row
  a_count: assert property (@(posedge clk) disable iff (rst)
    span_count <= CW'(DEPTH)) else $error("span count overflow");
  // no record is taken while a scan is open
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("accept during scan");
  // a span-full result always closes its record
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.span_full |-> out_ch.last_result)
    else $error("full result not last");
endmodule
